### design/least_squares_line_fit_top_macros.svh
// Assertion macros used by the line-fit solver.
`ifndef LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/lsf_pkg.sv
// Package with constants and types shared by the line-fit modules.
`timescale 1ns / 1ps
package lsf_pkg;
    localparam int MaxPoints   = 65536;
    localparam int SampleWidth = 16;
    localparam int CntW = 17;
    localparam int SumW = 32;
    localparam int SpqW = 48;
    localparam int NumW = 64;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusFew   = 2'd1;
    localparam logic [1:0] StatusZero  = 2'd2;
    localparam logic [1:0] StatusSat   = 2'd3;

    // Snapshot of the sums for one finished set.
    typedef struct packed {
        logic [CntW-1:0] cnt;
        logic [SumW-1:0] sx;
        logic [SumW-1:0] sy;
        logic [SpqW-1:0] sxy;
        logic [SpqW-1:0] sxx;
    } sums_t;
endpackage

### design/lsf_accum.sv
// Front part: accepts points and keeps the running sums.
`timescale 1ns / 1ps
module lsf_accum #(
    parameter int MAX_POINTS   = lsf_pkg::MaxPoints,
    parameter int SAMPLE_WIDTH = lsf_pkg::SampleWidth
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_WIDTH-1:0]  x_value,
    input  logic [SAMPLE_WIDTH-1:0]  y_value,
    input  logic                     last_point,
    output logic                     snap_valid,
    input  logic                     snap_ready,
    output lsf_pkg::sums_t           snap
);
    // Stage 1: register point and products; stage 2: add into sums.
    logic                            p_valid_reg;
    logic                            p_last_reg;
    logic signed [lsf_pkg::SumW-1:0] px_reg, py_reg;
    logic signed [lsf_pkg::SpqW-1:0] pxy_reg, pxx_reg;
    lsf_pkg::sums_t                  acc_reg, acc_next;
    logic                            snap_valid_reg;
    lsf_pkg::sums_t                  snap_reg;
    logic                            in_fire, p_done;
    logic signed [SAMPLE_WIDTH-1:0]  xs, ys;

    assign xs = x_value;
    assign ys = y_value;
    // A pending last point needs the snapshot slot free.
    assign p_done   = p_valid_reg && (!p_last_reg || !snap_valid_reg || snap_ready);
    assign in_ready = !p_valid_reg || p_done;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        acc_next = acc_reg;
        if (int'(acc_reg.cnt) < MAX_POINTS)
        begin
            acc_next.cnt = acc_reg.cnt + 1'b1;
            acc_next.sx  = acc_reg.sx + px_reg;
            acc_next.sy  = acc_reg.sy + py_reg;
            acc_next.sxy = acc_reg.sxy + pxy_reg;
            acc_next.sxx = acc_reg.sxx + pxx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg    <= 1'b0;
            p_last_reg     <= 1'b0;
            acc_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_done && p_last_reg)
                snap_valid_reg <= 1'b1;
            else if (snap_ready)
                snap_valid_reg <= 1'b0;
            if (p_done)
            begin
                if (p_last_reg)
                    acc_reg <= '0;
                else
                    acc_reg <= acc_next;
            end
            if (in_ready)
            begin
                p_valid_reg <= in_valid;
                p_last_reg  <= last_point;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_done && p_last_reg)
            snap_reg <= acc_next;
        if (in_fire)
        begin
            px_reg  <= lsf_pkg::SumW'(xs);
            py_reg  <= lsf_pkg::SumW'(ys);
            pxy_reg <= lsf_pkg::SpqW'(xs * ys);
            pxx_reg <= lsf_pkg::SpqW'(xs * xs);
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
endmodule

### design/lsf_solver.sv
// Back part: solves slope and intercept from one snapshot of sums.
`timescale 1ns / 1ps
module lsf_solver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_valid,
    output logic              snap_ready,
    input  lsf_pkg::sums_t    snap,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [31:0]       slope,
    output logic [31:0]       intercept,
    output logic [1:0]        fit_status
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_M1   = 12'b000000000010,
        S_M2   = 12'b000000000100,
        S_M3   = 12'b000000001000,
        S_M4   = 12'b000000010000,
        S_CHK  = 12'b000000100000,
        S_DIV  = 12'b000001000000,
        S_SL   = 12'b000010000000,
        S_MT   = 12'b000100000000,
        S_T    = 12'b001000000000,
        S_DIV2 = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    localparam int W = lsf_pkg::NumW;

    state_t         state_reg, state_next;
    lsf_pkg::sums_t s_reg;
    logic [W-1:0]   num_reg, den_reg, ta_reg;
    logic [W-1:0]   n_reg, d_reg, q_reg, r_reg;
    logic [6:0]     step_reg;
    logic           neg_reg, sat_reg, ovf_reg;
    logic [31:0]    slope_reg, icpt_reg;
    logic [1:0]     status_reg;
    logic [W-1:0]   sx64, sy64, sxy64, sxx64, cnt64, prod;
    logic [W-1:0]   rsh, a64, t_full, m_mag;
    logic [W-1:0]   rnd_q;
    logic           big;

    assign sx64  = W'(signed'(s_reg.sx));
    assign sy64  = W'(signed'(s_reg.sy));
    assign sxy64 = W'(signed'(s_reg.sxy));
    assign sxx64 = W'(signed'(s_reg.sxx));
    assign cnt64 = W'(s_reg.cnt);

    // One 64-bit product per state, registered before use.
    always_comb
    begin
        unique case (state_reg)
            S_M1:    prod = cnt64 * sxy64;
            S_M2:    prod = sx64 * sy64;
            S_M3:    prod = cnt64 * sxx64;
            S_M4:    prod = sx64 * sx64;
            S_MT:    prod = a64 * sx64;
            default: prod = '0;
        endcase
    end

    assign a64    = W'(signed'(slope_reg));
    assign t_full = (sy64 << 16) - ta_reg;
    assign rsh    = {r_reg[W-2:0], 1'b0};
    assign m_mag  = q_reg;
    // The integer part of the slope quotient reaches 2^16 or more.
    assign big    = ovf_reg || (q_reg[W-1:33] != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (snap_valid) state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_CHK;
            S_CHK:   state_next = (s_reg.cnt < lsf_pkg::CntW'(2) || den_reg == '0) ?
                                  S_OUT : S_DIV;
            S_DIV:   if (step_reg == 7'd0) state_next = S_SL;
            S_SL:    state_next = S_MT;
            S_MT:    state_next = S_T;
            S_T:     state_next = S_DIV2;
            S_DIV2:  if (step_reg == 7'd0) state_next = S_OUT;
            S_OUT:   if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Restoring divider, one quotient bit per cycle: 81 steps for the slope,
    // 64 for the intercept.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (snap_valid) s_reg <= snap;
            S_M1: num_reg <= prod;
            S_M2: num_reg <= num_reg - prod;
            S_M3: den_reg <= prod;
            S_M4:
                den_reg <= den_reg - prod;
            S_CHK:
            begin
                slope_reg  <= '0;
                icpt_reg   <= '0;
                sat_reg    <= 1'b0;
                ovf_reg    <= 1'b0;
                status_reg <= (s_reg.cnt < lsf_pkg::CntW'(2)) ?
                              lsf_pkg::StatusFew : lsf_pkg::StatusZero;
                neg_reg    <= num_reg[W-1] ^ den_reg[W-1];
                // The dividend is |num| followed by 17 zero bits, so the
                // quotient is floor(2^17 |num| / |den|).
                n_reg      <= num_reg[W-1] ? -num_reg : num_reg;
                d_reg      <= den_reg[W-1] ? -den_reg : den_reg;
                q_reg      <= '0;
                r_reg      <= '0;
                step_reg   <= 7'd80;
            end
            S_DIV, S_DIV2:
            begin
                if ({r_reg[W-2:0], n_reg[W-1]} >= d_reg)
                begin
                    r_reg <= {r_reg[W-2:0], n_reg[W-1]} - d_reg;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[W-2:0], n_reg[W-1]};
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                ovf_reg  <= ovf_reg | q_reg[W-1];
                n_reg    <= {n_reg[W-2:0], 1'b0};
                step_reg <= step_reg - 1'b1;
            end
            S_SL:
            begin
                // q holds floor(2^17 n/d); round half up then halve.
                if (big)
                begin
                    slope_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    sat_reg   <= 1'b1;
                end
                else if ((q_reg + 1'b1) >> 1 > 64'h7FFF_FFFF + W'(neg_reg))
                begin
                    slope_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    sat_reg   <= 1'b1;
                end
                else
                    slope_reg <= 32'(neg_reg ? -((q_reg + 1'b1) >> 1) : (q_reg + 1'b1) >> 1);
            end
            S_MT:
                ta_reg <= prod;
            S_T:
            begin
                neg_reg  <= t_full[W-1];
                n_reg    <= (t_full[W-1] ? -t_full : t_full) + (cnt64 << 7);
                d_reg    <= cnt64 << 8;
                q_reg    <= '0;
                r_reg    <= '0;
                step_reg <= 7'd63;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DIV2 && step_reg == 7'd0)
        begin
            if (rnd_q > 64'h7FFF_FFFF + W'(neg_reg))
            begin
                icpt_reg   <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                status_reg <= lsf_pkg::StatusSat;
            end
            else
            begin
                icpt_reg   <= 32'(neg_reg ? -rnd_q : rnd_q);
                status_reg <= sat_reg ? lsf_pkg::StatusSat : lsf_pkg::StatusOk;
            end
        end
    end

    // Final quotient including the bit resolved this cycle.
    assign rnd_q = {m_mag[W-2:0], ({r_reg[W-2:0], n_reg[W-1]} >= d_reg)};

    assign snap_ready = state_reg == S_IDLE;
    assign res_valid  = state_reg == S_OUT;
    assign slope      = slope_reg;
    assign intercept  = icpt_reg;
    assign fit_status = status_reg;

    `include "least_squares_line_fit_top_macros.svh"
    `LSF_ASSERT_NEXT(a_out_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(slope), "result changed while stalled")
    `LSF_ASSERT_IMP(a_one_hot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `LSF_ASSERT_IMP(a_take_idle, clk, rst_n, snap_ready, !res_valid, "snapshot taken while busy")
    `LSF_ASSERT_IMP(a_few_zero, clk, rst_n, res_valid && fit_status == lsf_pkg::StatusFew,
        slope == '0 && intercept == '0, "few points gave nonzero fit")
endmodule

### design/least_squares_line_fit_top.sv
// Top level of the least-squares line fit.
`timescale 1ns / 1ps
// Channel | Direction | Contents
// s_axis  | in        | tdata: x_value[15:0], y_value[31:16]; tlast: last_point
// m_axis  | out       | tdata: slope[31:0], intercept[63:32], fit_status[65:64]
// Points are taken one per cycle unless input stalls; each passes a product stage and an add stage.
// A last point hands its sums to the solver, which forms four products, runs an
// 81-step slope division, forms one more product and runs a 64-step division.
// A new set accumulates while the solver works; input stalls only when a second
// finished set waits for a busy solver. Reset is asynchronous and clears the running sums.
module least_squares_line_fit_top #(
    parameter int MAX_POINTS   = lsf_pkg::MaxPoints,
    parameter int SAMPLE_WIDTH = lsf_pkg::SampleWidth
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [2*SAMPLE_WIDTH-1:0] s_axis_tdata,   // x_value, y_value
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [71:0]               m_axis_tdata    // slope, intercept, fit_status
);
    logic           snap_valid, snap_ready;
    lsf_pkg::sums_t snap;
    logic [31:0]    slope, intercept;
    logic [1:0]     fit_status;

    lsf_accum #(.MAX_POINTS(MAX_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_accum (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .x_value(s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .y_value(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .last_point(s_axis_tlast),
        .snap_valid(snap_valid), .snap_ready(snap_ready), .snap(snap)
    );

    lsf_solver u_solver (
        .clk(clk), .rst_n(rst_n),
        .snap_valid(snap_valid), .snap_ready(snap_ready), .snap(snap),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .slope(slope), .intercept(intercept), .fit_status(fit_status)
    );

    assign m_axis_tdata = {6'd0, fit_status, intercept, slope};
endmodule
